// ----- sv/file_name_validator_macros.svh -----
// Assertion macros shared by the file name validator checker.
`ifndef FILE_NAME_VALIDATOR_MACROS_SVH
`define FILE_NAME_VALIDATOR_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define FNV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is held.
`define FNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fnv_pkg.sv -----
// Types and constants shared by the file name validator modules.
package fnv_pkg;

  // Longest name that is not reported as too long.
  localparam logic [15:0] MAX_NAME_UNITS = 16'd255;

  // Depth of the queue between the classifier and the verdict stage.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Stem length code meaning the stem can no longer be a device name.
  localparam logic [2:0] STEM_DEAD = 3'd5;

  localparam logic [16:0] POS_VALID = 17'h1FFFF;

  typedef enum logic [2:0] {
    PR_NONE      = 3'd0,
    PR_EMPTY     = 3'd1,
    PR_DOTS      = 3'd2,
    PR_CONTROL   = 3'd3,
    PR_FORBIDDEN = 3'd4,
    PR_TRAILING  = 3'd5,
    PR_RESERVED  = 3'd6,
    PR_TOO_LONG  = 3'd7
  } problem_t;

  typedef enum logic [1:0] {
    CP_NONE      = 2'd0,
    CP_CONTROL   = 2'd1,
    CP_FORBIDDEN = 2'd2
  } char_problem_t;

  // One classified code unit as it travels from the front to the back.
  typedef struct packed {
    logic          empty_item;
    logic          final_item;
    char_problem_t char_problem;
    logic          is_dot;
    logic          is_space;
    logic          is_ascii;
    logic [6:0]    stem_char;
  } unit_class_t;

endpackage

// ----- sv/fnv_front.sv -----
// Front end: accepts code unit beats and classifies each one.
module fnv_front
  import fnv_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_final_unit,
  input  logic        in_empty_name,
  input  logic        q_full,
  output logic        q_push,
  output unit_class_t q_wdata
);

  logic       raw;
  logic       control;
  logic       forbidden;
  logic [6:0] low7;

  assign raw       = (in_code_unit >= 16'hDC80) && (in_code_unit <= 16'hDCFF);
  assign control   = (in_code_unit < 16'h0020) || (in_code_unit == 16'h007F);
  assign forbidden = (in_code_unit == 16'h003C) || (in_code_unit == 16'h003E) ||
                     (in_code_unit == 16'h003A) || (in_code_unit == 16'h0022) ||
                     (in_code_unit == 16'h002F) || (in_code_unit == 16'h005C) ||
                     (in_code_unit == 16'h007C) || (in_code_unit == 16'h003F) ||
                     (in_code_unit == 16'h002A);
  assign low7      = in_code_unit[6:0];

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata            = '0;
    q_wdata.empty_item = in_empty_name;
    q_wdata.final_item = in_final_unit;
    if (raw) begin
      q_wdata.char_problem = CP_NONE;
    end else if (control) begin
      q_wdata.char_problem = CP_CONTROL;
    end else if (forbidden) begin
      q_wdata.char_problem = CP_FORBIDDEN;
    end else begin
      q_wdata.char_problem = CP_NONE;
    end
    q_wdata.is_dot   = (in_code_unit == 16'h002E);
    q_wdata.is_space = (in_code_unit == 16'h0020);
    q_wdata.is_ascii = (in_code_unit < 16'h0080);
    // Lower-case ASCII letters are folded to upper case for the stem compare.
    if ((low7 >= 7'h61) && (low7 <= 7'h7A)) begin
      q_wdata.stem_char = low7 - 7'h20;
    end else begin
      q_wdata.stem_char = low7;
    end
  end

endmodule

// ----- sv/fnv_queue.sv -----
// Small register queue between the classifier and the verdict stage.
module fnv_queue
  import fnv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  unit_class_t wdata,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output unit_class_t rdata
);

  unit_class_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]        count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/fnv_back.sv -----
// Back end: keeps the per-name state and registers one verdict per name.
module fnv_back
  import fnv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  unit_class_t        q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_problem,
  output logic signed [16:0] out_position
);

  logic [15:0]   unit_count_r, unit_count_nxt, count_upd;
  char_problem_t fcp_r, fcp_nxt, fcp_upd;
  logic [15:0]   fcp_pos_r, fcp_pos_nxt, fcp_pos_upd;
  logic          all_dots_r, all_dots_nxt, all_dots_upd;
  logic [6:0]    stem_r [4];
  logic [6:0]    stem_nxt [4];
  logic [6:0]    stem_upd [4];
  logic [2:0]    stem_len_r, stem_len_nxt, stem_len_upd;
  logic          stem_closed_r, stem_closed_nxt, stem_closed_upd;

  logic          out_valid_r, out_valid_nxt;
  problem_t      problem_r, problem_nxt;
  logic [16:0]   position_r, position_nxt;

  logic          terminal;
  logic          reserved;
  logic          stem3_plain;
  logic          stem3_port;

  assign terminal = q_rdata.empty_item || q_rdata.final_item;
  assign q_pop    = q_not_empty && (!terminal || !out_valid_r || out_ready);

  // State after taking the head unit.
  always_comb begin
    count_upd       = (unit_count_r == 16'hFFFF) ? unit_count_r : unit_count_r + 16'd1;
    fcp_upd         = fcp_r;
    fcp_pos_upd     = fcp_pos_r;
    if ((fcp_r == CP_NONE) && (q_rdata.char_problem != CP_NONE)) begin
      fcp_upd     = q_rdata.char_problem;
      fcp_pos_upd = unit_count_r;
    end
    all_dots_upd    = all_dots_r && q_rdata.is_dot;
    stem_upd        = stem_r;
    stem_len_upd    = stem_len_r;
    stem_closed_upd = stem_closed_r;
    if (!stem_closed_r) begin
      if (q_rdata.is_dot) begin
        stem_closed_upd = 1'b1;
      end else if ((stem_len_r < 3'd4) && q_rdata.is_ascii) begin
        stem_upd[stem_len_r[1:0]] = q_rdata.stem_char;
        stem_len_upd              = stem_len_r + 3'd1;
      end else begin
        stem_len_upd = STEM_DEAD;
      end
    end
  end

  // Device name match on the updated stem.
  always_comb begin
    stem3_plain = ((stem_upd[0] == 7'h43) && (stem_upd[1] == 7'h4F) && (stem_upd[2] == 7'h4E)) ||
                  ((stem_upd[0] == 7'h50) && (stem_upd[1] == 7'h52) && (stem_upd[2] == 7'h4E)) ||
                  ((stem_upd[0] == 7'h41) && (stem_upd[1] == 7'h55) && (stem_upd[2] == 7'h58)) ||
                  ((stem_upd[0] == 7'h4E) && (stem_upd[1] == 7'h55) && (stem_upd[2] == 7'h4C));
    stem3_port  = ((stem_upd[0] == 7'h43) && (stem_upd[1] == 7'h4F) && (stem_upd[2] == 7'h4D)) ||
                  ((stem_upd[0] == 7'h4C) && (stem_upd[1] == 7'h50) && (stem_upd[2] == 7'h54));
    reserved    = ((stem_len_upd == 3'd3) && stem3_plain) ||
                  ((stem_len_upd == 3'd4) && (stem_upd[3] >= 7'h31) &&
                   (stem_upd[3] <= 7'h39) && stem3_port);
  end

  // Next state: a terminal beat returns everything to its reset value.
  always_comb begin
    unit_count_nxt  = unit_count_r;
    fcp_nxt         = fcp_r;
    fcp_pos_nxt     = fcp_pos_r;
    all_dots_nxt    = all_dots_r;
    stem_nxt        = stem_r;
    stem_len_nxt    = stem_len_r;
    stem_closed_nxt = stem_closed_r;
    if (q_pop) begin
      if (terminal) begin
        unit_count_nxt  = '0;
        fcp_nxt         = CP_NONE;
        fcp_pos_nxt     = '0;
        all_dots_nxt    = 1'b1;
        stem_nxt        = '{default: '0};
        stem_len_nxt    = '0;
        stem_closed_nxt = 1'b0;
      end else begin
        unit_count_nxt  = count_upd;
        fcp_nxt         = fcp_upd;
        fcp_pos_nxt     = fcp_pos_upd;
        all_dots_nxt    = all_dots_upd;
        stem_nxt        = stem_upd;
        stem_len_nxt    = stem_len_upd;
        stem_closed_nxt = stem_closed_upd;
      end
    end
  end

  // Verdict, checks in priority order.
  always_comb begin
    problem_nxt  = problem_r;
    position_nxt = position_r;
    if (q_pop && terminal) begin
      if (q_rdata.empty_item) begin
        problem_nxt  = PR_EMPTY;
        position_nxt = '0;
      end else if (fcp_upd == CP_CONTROL) begin
        problem_nxt  = PR_CONTROL;
        position_nxt = {1'b0, fcp_pos_upd};
      end else if (fcp_upd == CP_FORBIDDEN) begin
        problem_nxt  = PR_FORBIDDEN;
        position_nxt = {1'b0, fcp_pos_upd};
      end else if (all_dots_upd && ((count_upd == 16'd1) || (count_upd == 16'd2))) begin
        problem_nxt  = PR_DOTS;
        position_nxt = '0;
      end else if (q_rdata.is_space || q_rdata.is_dot) begin
        problem_nxt  = PR_TRAILING;
        position_nxt = {1'b0, unit_count_r};
      end else if (count_upd > MAX_NAME_UNITS) begin
        problem_nxt  = PR_TOO_LONG;
        position_nxt = {1'b0, MAX_NAME_UNITS};
      end else if (reserved) begin
        problem_nxt  = PR_RESERVED;
        position_nxt = '0;
      end else begin
        problem_nxt  = PR_NONE;
        position_nxt = POS_VALID;
      end
    end
  end

  always_comb begin
    if (q_pop && terminal) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r  <= '0;
      fcp_r         <= CP_NONE;
      fcp_pos_r     <= '0;
      all_dots_r    <= 1'b1;
      stem_r        <= '{default: '0};
      stem_len_r    <= '0;
      stem_closed_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      unit_count_r  <= unit_count_nxt;
      fcp_r         <= fcp_nxt;
      fcp_pos_r     <= fcp_pos_nxt;
      all_dots_r    <= all_dots_nxt;
      stem_r        <= stem_nxt;
      stem_len_r    <= stem_len_nxt;
      stem_closed_r <= stem_closed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    problem_r  <= problem_nxt;
    position_r <= position_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_problem  = problem_r;
  assign out_position = $signed(position_r);

endmodule

// ----- sv/file_name_validator.sv -----
// Top level of the file name validator: classifier, queue and verdict stage.
//
//   channel   direction  beat contents                          handshake
//   in_       input      code_unit, final_unit, empty_name      in_valid / in_ready
//   out_      output     problem, position                      out_valid / out_ready
//
// One code unit beat is taken in every clock cycle while the two-entry queue
// has room; the verdict stage drains the queue at one beat per cycle while
// no final or empty beat waits on an untaken verdict. A verdict is written
// to the output register when its final or empty beat is popped from the queue.
// A stalled output only holds back final and empty beats; the queue keeps
// accepting until both entries are occupied.
// Synchronous active-low reset clears the queue, the name state and out_valid.
module file_name_validator
  import fnv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_code_unit,
  input  logic               in_final_unit,
  input  logic               in_empty_name,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_problem,
  output logic signed [16:0] out_position
);

  // Classified beats queued between the front and the back.
  unit_class_t q_wdata;
  unit_class_t q_rdata;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;

  // The front classifies each unit and pushes it whenever the queue has room.
  fnv_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_unit  (in_code_unit),
    .in_final_unit (in_final_unit),
    .in_empty_name (in_empty_name),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // The queue decouples input stalls from output stalls.
  fnv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // The back keeps the per-name state and produces the verdict.
  fnv_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_problem  (out_problem),
    .out_position (out_position)
  );

endmodule

// ----- sv/fnv_checker.sv -----
// Port-level checker for the file name validator, bound to the top level.
`include "file_name_validator_macros.svh"

module fnv_checker
  import fnv_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_problem,
  input logic signed [16:0] out_position
);

  logic is_none;
  logic is_whole;
  logic is_long;

  assign is_none  = (out_problem == PR_NONE);
  assign is_whole = (out_problem == PR_EMPTY) || (out_problem == PR_DOTS) ||
                    (out_problem == PR_RESERVED);
  assign is_long  = (out_problem == PR_TOO_LONG);

  // Reset leaves no verdict pending.
  `FNV_ASSERT_NEXT(a_reset_clears, !rst_n, !out_valid, "out_valid set after reset")

  // A verdict waits until it is taken.
  `FNV_ASSERT_IMPL(a_out_hold, out_valid && !out_ready, ##1 out_valid, "verdict dropped")

  // A valid name always reports the position of minus one.
  `FNV_ASSERT_IMPL(a_none_pos, out_valid && is_none, out_position == -17'sd1, "bad valid position")

  // Whole-name problems report position zero.
  `FNV_ASSERT_IMPL(a_whole_pos, out_valid && is_whole, out_position == 17'sd0, "bad whole position")

  // Over-long names report the length limit.
  `FNV_ASSERT_IMPL(a_long_pos, out_valid && is_long, out_position == $signed({1'b0, MAX_NAME_UNITS}), "bad long position")

endmodule

bind file_name_validator fnv_checker u_fnv_checker (.*);
